// ----- hw/rtl/imu_tilt_complementary_filter_macros.svh -----
// Assertion macros for the tilt filter checker.
`ifndef IMU_TILT_COMPLEMENTARY_FILTER_MACROS_SVH
`define IMU_TILT_COMPLEMENTARY_FILTER_MACROS_SVH

// same-cycle implication, reset masks the check
`define ITCF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masks the check
`define ITCF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/itcf_pkg.sv -----
// Shared types, constants and lookup functions for the tilt complementary filter.
`timescale 1ns / 1ps

package itcf_pkg;

   localparam int CORDIC_ITERATIONS_DEF = 16;

   localparam int REQ_W   = 120;
   localparam int RSP_W   = 64;
   localparam int CSR_W   = 48;
   localparam int CSR_A_W = 3;

   localparam int CNT_W   = 6;
   localparam int VEC_W   = 28;
   localparam int ANG_W   = 26;
   localparam int SMP_W   = 17;
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 22;
   localparam int MUL_W   = MUL_A_W + MUL_B_W;
   localparam int DIV_W   = 28;
   localparam int RAD_W   = 48;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int SREM_W  = ROOT_W + 2;

   localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_W - 1);

   localparam logic [19:0] STEP_MAX  = 20'd1000000;
   localparam logic [16:0] ALPHA_ONE = 17'd65536;
   localparam logic signed [ANG_W-1:0] ANG_Q90 = 26'sd5898240;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_ACCEL_RANGE   = 3'd0,
      CSR_GYRO_RANGE    = 3'd1,
      CSR_BLEND_WEIGHT  = 3'd2,
      CSR_AXIS_MAP      = 3'd3,
      CSR_ACCEL_OFFSETS = 3'd4,
      CSR_GYRO_OFFSETS  = 3'd5,
      CSR_START_ROLL    = 3'd6,
      CSR_START_PITCH   = 3'd7
   } csr_addr_type;

   typedef enum logic [12:0] {
      ST_IDLE = 13'b0000000000001,
      ST_SQY  = 13'b0000000000010,
      ST_SQZ  = 13'b0000000000100,
      ST_SQS  = 13'b0000000001000,
      ST_ROOT = 13'b0000000010000,
      ST_CRD  = 13'b0000000100000,
      ST_GM   = 13'b0000001000000,
      ST_DVL  = 13'b0000010000000,
      ST_DV   = 13'b0000100000000,
      ST_BL1  = 13'b0001000000000,
      ST_BL2  = 13'b0010000000000,
      ST_BL3  = 13'b0100000000000,
      ST_OUT  = 13'b1000000000000
   } state_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
   } cordic_type;

   // atan(2^-i) in Q16.16 degrees
   function automatic logic signed [ANG_W-1:0] atan_lut(logic [4:0] i);
      logic signed [ANG_W-1:0] r;
      case (i)
         5'd0:  r = 26'sd2949120;
         5'd1:  r = 26'sd1740967;
         5'd2:  r = 26'sd919879;
         5'd3:  r = 26'sd466945;
         5'd4:  r = 26'sd234379;
         5'd5:  r = 26'sd117304;
         5'd6:  r = 26'sd58666;
         5'd7:  r = 26'sd29335;
         5'd8:  r = 26'sd14668;
         5'd9:  r = 26'sd7334;
         5'd10: r = 26'sd3667;
         5'd11: r = 26'sd1833;
         5'd12: r = 26'sd917;
         5'd13: r = 26'sd458;
         5'd14: r = 26'sd229;
         5'd15: r = 26'sd115;
         5'd16: r = 26'sd57;
         5'd17: r = 26'sd29;
         5'd18: r = 26'sd14;
         5'd19: r = 26'sd7;
         5'd20: r = 26'sd4;
         5'd21: r = 26'sd2;
         5'd22: r = 26'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // gyro LSB per dps times 1e6, the divisor of rate*dt*65536
   function automatic logic [26:0] den_lut(logic [1:0] rng);
      logic [26:0] r;
      case (rng)
         2'd0:    r = 27'd131000000;
         2'd1:    r = 27'd65500000;
         2'd2:    r = 27'd32800000;
         default: r = 27'd16400000;
      endcase
      return r;
   endfunction

   function automatic logic [26:0] den_half_lut(logic [1:0] rng);
      logic [26:0] r;
      case (rng)
         2'd0:    r = 27'd65500000;
         2'd1:    r = 27'd32750000;
         2'd2:    r = 27'd16400000;
         default: r = 27'd8200000;
      endcase
      return r;
   endfunction

   // select a source axis for one body axis, optionally negated
   function automatic logic signed [SMP_W-1:0] pick_axis(logic [1:0] src, logic neg,
         logic signed [15:0] v0, logic signed [15:0] v1, logic signed [15:0] v2);
      logic signed [SMP_W-1:0] r;
      case (src)
         AXIS_X:  r = SMP_W'(v0);
         AXIS_Y:  r = SMP_W'(v1);
         AXIS_Z:  r = SMP_W'(v2);
         default: r = '0;
      endcase
      return neg ? -r : r;
   endfunction

   // quadrant fold so the vectoring loop starts in the right half plane
   function automatic cordic_type cordic_load(logic signed [VEC_W-1:0] y,
         logic signed [VEC_W-1:0] x);
      cordic_type c;
      c.x = x;
      c.y = y;
      c.z = '0;
      if (x < 0) begin
         if (y >= 0) begin
            c.x = y;
            c.y = -x;
            c.z = ANG_Q90;
         end else begin
            c.x = -y;
            c.y = x;
            c.z = -ANG_Q90;
         end
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/imu_tilt_complementary_filter.sv -----
// Tilt estimator: roll and pitch from one six-axis sample per request.
// req channel: tuser = action (1 loads start angles, 0 updates from the sample);
//   tdata = accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, step_us from bit 0 up.
// rsp channel: tdata = roll_angle, pitch_angle (Q16.16 degrees); tuser = status.
// csr port: write-only, csr_addr selects the register, csr_wdata the value;
//   write only while no request is in flight.
// One request at a time: req_tready is high only while the sequencer is idle.
// An update request runs these steps in turn: two 17x17 squares, a 24-step
// square root, two CORDIC passes (each may stop early on y == 0), and per angle
// one rate multiply, a 28-step restoring divide and two blend multiplies, the
// squares and multiplies all on one shared multiplier.
// A load request or a zero step skips these steps and goes straight from idle
// to the output state.
// req_tready rises in the same cycle as the result appears.
// The result sits in an output register; if the receiver stalls, the next
// request is still accepted, and the block waits at the end of that request
// until the held result is taken.
// Reset clears the estimates to zero, loads the default registers
// (blend weight 64225, axis map 36) and empties the output register.
`timescale 1ns / 1ps

module imu_tilt_complementary_filter #(
   parameter int CORDIC_ITERATIONS = itcf_pkg::CORDIC_ITERATIONS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, step_us, zero pad
   input  logic [itcf_pkg::REQ_W-1:0]    req_tdata,
   // action
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // roll_angle, pitch_angle
   output logic [itcf_pkg::RSP_W-1:0]    rsp_tdata,
   // status
   output logic                          rsp_tuser,
   input  logic                          csr_we,
   input  logic [itcf_pkg::CSR_A_W-1:0]  csr_addr,
   input  logic [itcf_pkg::CSR_W-1:0]    csr_wdata
);

   localparam int CNT_W = itcf_pkg::CNT_W;
   localparam int VEC_W = itcf_pkg::VEC_W;
   localparam int ANG_W = itcf_pkg::ANG_W;
   localparam int SMP_W = itcf_pkg::SMP_W;
   localparam int MUL_W = itcf_pkg::MUL_W;
   localparam int MA_W  = itcf_pkg::MUL_A_W;
   localparam int MB_W  = itcf_pkg::MUL_B_W;
   localparam int DIV_W = itcf_pkg::DIV_W;
   localparam int RAD_W = itcf_pkg::RAD_W;
   localparam int RT_W  = itcf_pkg::ROOT_W;
   localparam int SR_W  = itcf_pkg::SREM_W;
   localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(CORDIC_ITERATIONS);

   // configuration (accel_range cancels in atan2 and is not stored)
   logic [1:0]  gyro_range_ff;
   logic [16:0] blend_ff;
   logic [8:0]  axis_map_ff;
   logic [47:0] acc_off_ff;
   logic [47:0] gyr_off_ff;
   logic signed [31:0] start_roll_ff;
   logic signed [31:0] start_pitch_ff;

   itcf_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic sel_ff, sel_in;

   logic signed [SMP_W-1:0] ax_ff, ay_ff, az_ff, gx_ff, gy_ff;
   logic signed [SMP_W-1:0] ax_in, ay_in, az_in, gx_in, gy_in;
   logic [19:0] step_ff, step_in;

   logic signed [MUL_W-1:0] mul_ff, mul_in, acc_ff, acc_in;
   logic signed [MA_W-1:0]  mul_a;
   logic signed [MB_W-1:0]  mul_b;

   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [RT_W-1:0]  root_ff, root_in;
   logic [SR_W-1:0]  srem_ff, srem_in;

   itcf_pkg::cordic_type crd_ff, crd_in;
   logic signed [ANG_W-1:0] rr_ff, rr_in, pr_ff, pr_in;

   logic [DIV_W-1:0] dv_rem_ff, dv_rem_in, dv_q_ff, dv_q_in;
   logic dv_neg_ff, dv_neg_in;
   logic signed [DIV_W:0] d_ff, d_in;

   logic signed [31:0] res_roll_ff, res_roll_in, res_pitch_ff, res_pitch_in;
   logic res_stat_ff, res_stat_in;
   logic signed [31:0] est_roll_ff, est_roll_in, est_pitch_ff, est_pitch_in;

   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic [itcf_pkg::RSP_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic rsp_tuser_ff, rsp_tuser_in;

   // request fields
   logic signed [15:0] f_acc [3];
   logic signed [15:0] f_gyr [3];
   logic [19:0] f_step;
   logic signed [15:0] cor_a [3];
   logic signed [15:0] cor_g [3];

   logic req_fire;
   logic [16:0] alpha;
   logic [26:0] den;

   // scratch for the datapath
   logic [SR_W-1:0] sq_rem2, sq_trial;
   logic signed [VEC_W-1:0] sh_x, sh_y;
   logic signed [ANG_W-1:0] atan_i;
   logic [MUL_W-1:0] mul_mag;
   logic [51:0] numer;
   logic [DIV_W-1:0] dv_shift, dv_qn;
   logic dv_bit;
   logic signed [MUL_W-1:0] bl_sum, bl_rnd, bl_q;
   logic signed [31:0] bl_sat;
   logic signed [31:0] est_sel;

   assign req_tready = (state_ff == itcf_pkg::ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   assign alpha = (blend_ff > itcf_pkg::ALPHA_ONE) ? itcf_pkg::ALPHA_ONE : blend_ff;
   assign den   = itcf_pkg::den_lut(gyro_range_ff);
   assign est_sel = sel_ff ? est_pitch_ff : est_roll_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         f_acc[k] = req_tdata[16*k +: 16];
         f_gyr[k] = req_tdata[48 + 16*k +: 16];
         cor_a[k] = f_acc[k] - acc_off_ff[16*k +: 16];
         cor_g[k] = f_gyr[k] - gyr_off_ff[16*k +: 16];
      end
      f_step = req_tdata[96 +: 20];
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         itcf_pkg::ST_SQY: begin
            mul_a = MA_W'(ay_ff);
            mul_b = MB_W'(ay_ff);
         end
         itcf_pkg::ST_SQZ: begin
            mul_a = MA_W'(az_ff);
            mul_b = MB_W'(az_ff);
         end
         itcf_pkg::ST_GM: begin
            mul_a = MA_W'(sel_ff ? gy_ff : gx_ff);
            mul_b = $signed({2'b00, step_ff});
         end
         itcf_pkg::ST_BL1: begin
            mul_a = MA_W'(est_sel) + MA_W'(d_ff);
            mul_b = $signed({5'b0, alpha});
         end
         itcf_pkg::ST_BL2: begin
            mul_a = MA_W'(sel_ff ? pr_ff : rr_ff);
            mul_b = $signed({5'b0, itcf_pkg::ALPHA_ONE - alpha});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_in = MUL_W'(mul_a) * MUL_W'(mul_b);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sel_in       = sel_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      srem_in      = srem_ff;
      crd_in       = crd_ff;
      rr_in        = rr_ff;
      pr_in        = pr_ff;
      dv_rem_in    = dv_rem_ff;
      dv_q_in      = dv_q_ff;
      dv_neg_in    = dv_neg_ff;
      d_in         = d_ff;
      res_roll_in  = res_roll_ff;
      res_pitch_in = res_pitch_ff;
      res_stat_in  = res_stat_ff;
      est_roll_in  = est_roll_ff;
      est_pitch_in = est_pitch_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;

      sq_rem2  = {srem_ff[SR_W-3:0], rad_ff[RAD_W-1 -: 2]};
      sq_trial = {root_ff, 2'b01};

      sh_x   = crd_ff.x >>> cnt_ff[4:0];
      sh_y   = crd_ff.y >>> cnt_ff[4:0];
      atan_i = itcf_pkg::atan_lut(cnt_ff[4:0]);

      mul_mag = mul_ff[MUL_W-1] ? MUL_W'(-mul_ff) : MUL_W'(mul_ff);
      numer   = {mul_mag[35:0], 16'b0} + 52'(itcf_pkg::den_half_lut(gyro_range_ff));

      dv_shift = {dv_rem_ff[DIV_W-2:0], dv_q_ff[DIV_W-1]};
      dv_bit   = (dv_shift >= DIV_W'(den));
      dv_qn    = {dv_q_ff[DIV_W-2:0], dv_bit};

      bl_sum = acc_ff + mul_ff;
      bl_rnd = bl_sum + (bl_sum[MUL_W-1] ? MUL_W'(32767) : MUL_W'(32768));
      bl_q   = bl_rnd >>> 16;
      if (bl_q > MUL_W'(32'sh7fffffff)) begin
         bl_sat = 32'sh7fffffff;
      end else if (bl_q < -MUL_W'(64'sh80000000)) begin
         bl_sat = 32'sh80000000;
      end else begin
         bl_sat = bl_q[31:0];
      end

      case (state_ff)
         itcf_pkg::ST_IDLE: begin
            if (req_fire) begin
               ax_in = itcf_pkg::pick_axis(axis_map_ff[1:0], axis_map_ff[6],
                                           cor_a[0], cor_a[1], cor_a[2]);
               ay_in = itcf_pkg::pick_axis(axis_map_ff[3:2], axis_map_ff[7],
                                           cor_a[0], cor_a[1], cor_a[2]);
               az_in = itcf_pkg::pick_axis(axis_map_ff[5:4], axis_map_ff[8],
                                           cor_a[0], cor_a[1], cor_a[2]);
               gx_in = itcf_pkg::pick_axis(axis_map_ff[1:0], axis_map_ff[6],
                                           cor_g[0], cor_g[1], cor_g[2]);
               gy_in = itcf_pkg::pick_axis(axis_map_ff[3:2], axis_map_ff[7],
                                           cor_g[0], cor_g[1], cor_g[2]);
               step_in = (f_step > itcf_pkg::STEP_MAX) ? itcf_pkg::STEP_MAX : f_step;
               sel_in  = 1'b0;
               res_stat_in = 1'b0;
               if (req_tuser) begin
                  res_roll_in  = start_roll_ff;
                  res_pitch_in = start_pitch_ff;
                  state_in     = itcf_pkg::ST_OUT;
               end else if (f_step == '0) begin
                  res_roll_in  = est_roll_ff;
                  res_pitch_in = est_pitch_ff;
                  res_stat_in  = 1'b1;
                  state_in     = itcf_pkg::ST_OUT;
               end else begin
                  state_in = itcf_pkg::ST_SQY;
               end
            end
         end
         itcf_pkg::ST_SQY: state_in = itcf_pkg::ST_SQZ;
         itcf_pkg::ST_SQZ: begin
            acc_in   = mul_ff;
            state_in = itcf_pkg::ST_SQS;
         end
         itcf_pkg::ST_SQS: begin
            rad_in   = {32'(acc_ff + mul_ff), 16'b0};
            root_in  = '0;
            srem_in  = '0;
            cnt_in   = '0;
            state_in = itcf_pkg::ST_ROOT;
         end
         itcf_pkg::ST_ROOT: begin
            rad_in = rad_ff << 2;
            if (sq_rem2 >= sq_trial) begin
               srem_in = sq_rem2 - sq_trial;
               root_in = {root_ff[RT_W-2:0], 1'b1};
            end else begin
               srem_in = sq_rem2;
               root_in = {root_ff[RT_W-2:0], 1'b0};
            end
            if (cnt_ff == itcf_pkg::ROOT_LAST) begin
               crd_in   = itcf_pkg::cordic_load(VEC_W'(ay_ff) <<< 8, VEC_W'(az_ff) <<< 8);
               cnt_in   = '0;
               state_in = itcf_pkg::ST_CRD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         itcf_pkg::ST_CRD: begin
            if (cnt_ff == ITER_LAST || crd_ff.y == '0) begin
               cnt_in = '0;
               if (!sel_ff) begin
                  rr_in  = crd_ff.z;
                  crd_in = itcf_pkg::cordic_load(-(VEC_W'(ax_ff) <<< 8),
                                                 $signed(VEC_W'(root_ff)));
                  sel_in = 1'b1;
               end else begin
                  pr_in    = crd_ff.z;
                  sel_in   = 1'b0;
                  state_in = itcf_pkg::ST_GM;
               end
            end else begin
               // rotate toward the x axis
               if (crd_ff.y > 0) begin
                  crd_in.x = crd_ff.x + sh_y;
                  crd_in.y = crd_ff.y - sh_x;
                  crd_in.z = crd_ff.z + atan_i;
               end else begin
                  crd_in.x = crd_ff.x - sh_y;
                  crd_in.y = crd_ff.y + sh_x;
                  crd_in.z = crd_ff.z - atan_i;
               end
               cnt_in = cnt_ff + 1'b1;
            end
         end
         itcf_pkg::ST_GM: state_in = itcf_pkg::ST_DVL;
         itcf_pkg::ST_DVL: begin
            // quotient fits in DIV_W bits, so the upper numerator bits start the remainder
            dv_rem_in = DIV_W'(numer[51:DIV_W]);
            dv_q_in   = numer[DIV_W-1:0];
            dv_neg_in = mul_ff[MUL_W-1];
            cnt_in    = '0;
            state_in  = itcf_pkg::ST_DV;
         end
         itcf_pkg::ST_DV: begin
            dv_rem_in = dv_bit ? (dv_shift - DIV_W'(den)) : dv_shift;
            dv_q_in   = dv_qn;
            if (cnt_ff == itcf_pkg::DIV_LAST) begin
               d_in = dv_neg_ff ? -$signed({1'b0, dv_qn}) : $signed({1'b0, dv_qn});
               state_in = itcf_pkg::ST_BL1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         itcf_pkg::ST_BL1: state_in = itcf_pkg::ST_BL2;
         itcf_pkg::ST_BL2: begin
            acc_in   = mul_ff;
            state_in = itcf_pkg::ST_BL3;
         end
         itcf_pkg::ST_BL3: begin
            if (!sel_ff) begin
               res_roll_in = bl_sat;
               sel_in      = 1'b1;
               state_in    = itcf_pkg::ST_GM;
            end else begin
               res_pitch_in = bl_sat;
               sel_in       = 1'b0;
               state_in     = itcf_pkg::ST_OUT;
            end
         end
         itcf_pkg::ST_OUT: begin
            // hold until the previous response is taken
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {res_pitch_ff, res_roll_ff};
               rsp_tuser_in  = res_stat_ff;
               est_roll_in   = res_roll_ff;
               est_pitch_in  = res_pitch_ff;
               state_in      = itcf_pkg::ST_IDLE;
            end
         end
         default: state_in = itcf_pkg::ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= itcf_pkg::ST_IDLE;
         cnt_ff        <= '0;
         sel_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         est_roll_ff   <= '0;
         est_pitch_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         sel_ff        <= sel_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         est_roll_ff   <= est_roll_in;
         est_pitch_ff  <= est_pitch_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      az_ff        <= az_in;
      gx_ff        <= gx_in;
      gy_ff        <= gy_in;
      step_ff      <= step_in;
      mul_ff       <= mul_in;
      acc_ff       <= acc_in;
      rad_ff       <= rad_in;
      root_ff      <= root_in;
      srem_ff      <= srem_in;
      crd_ff       <= crd_in;
      rr_ff        <= rr_in;
      pr_ff        <= pr_in;
      dv_rem_ff    <= dv_rem_in;
      dv_q_ff      <= dv_q_in;
      dv_neg_ff    <= dv_neg_in;
      d_ff         <= d_in;
      res_roll_ff  <= res_roll_in;
      res_pitch_ff <= res_pitch_in;
      res_stat_ff  <= res_stat_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_range_ff  <= '0;
         blend_ff       <= 17'd64225;
         axis_map_ff    <= 9'd36;
         acc_off_ff     <= '0;
         gyr_off_ff     <= '0;
         start_roll_ff  <= '0;
         start_pitch_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            itcf_pkg::CSR_GYRO_RANGE:    gyro_range_ff  <= csr_wdata[1:0];
            itcf_pkg::CSR_BLEND_WEIGHT:  blend_ff       <= csr_wdata[16:0];
            itcf_pkg::CSR_AXIS_MAP:      axis_map_ff    <= csr_wdata[8:0];
            itcf_pkg::CSR_ACCEL_OFFSETS: acc_off_ff     <= csr_wdata;
            itcf_pkg::CSR_GYRO_OFFSETS:  gyr_off_ff     <= csr_wdata;
            itcf_pkg::CSR_START_ROLL:    start_roll_ff  <= csr_wdata[31:0];
            itcf_pkg::CSR_START_PITCH:   start_pitch_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

endmodule

// ----- hw/rtl/itcf_checker.sv -----
// Port-level checker for the tilt filter, bound to the top level.
`timescale 1ns / 1ps
`include "imu_tilt_complementary_filter_macros.svh"

module itcf_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [itcf_pkg::REQ_W-1:0] req_tdata,
   input logic                       req_tuser,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [itcf_pkg::RSP_W-1:0] rsp_tdata,
   input logic                       rsp_tuser
);

   logic req_fire;
   logic out_free;

   assign req_fire = req_tvalid & req_tready;
   assign out_free = ~rsp_tvalid | rsp_tready;

   `ITCF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_fire, !req_tready, "ready while busy")
   `ITCF_ASSERT_NOW(a_rsp_rises_idle, clock, reset, $rose(rsp_tvalid), req_tready, "response before idle")
   `ITCF_ASSERT_NEXT(a_zero_step, clock, reset, req_fire && !req_tuser && req_tdata[115:96] == 20'd0 && out_free, ##1 (rsp_tvalid && rsp_tuser), "zero step not flagged")
   `ITCF_ASSERT_NEXT(a_load_ok, clock, reset, req_fire && req_tuser && out_free, ##1 (rsp_tvalid && !rsp_tuser), "load not answered")
   `ITCF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")

endmodule

bind imu_tilt_complementary_filter itcf_checker u_itcf_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for the IMU tilt complementary filter.
`timescale 1ns / 1ps

module tb;

   localparam int STEP_LIMIT = 3000000;

   typedef struct {
      logic                 action;
      logic signed [15:0]   acc [3];
      logic signed [15:0]   gyr [3];
      logic [19:0]          step_us;
   } tilt_req_type;

   typedef struct {
      logic signed [31:0] roll;
      logic signed [31:0] pitch;
      logic               status;
   } tilt_rsp_type;

   typedef struct {
      tilt_req_type req;
      logic         known;
      tilt_rsp_type rsp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [itcf_pkg::REQ_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [itcf_pkg::RSP_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we = 1'b0;
   logic [itcf_pkg::CSR_A_W-1:0] csr_addr = '0;
   logic [itcf_pkg::CSR_W-1:0] csr_wdata = '0;

   // predictor copy of registers and estimates
   logic [1:0]  m_grange;
   logic [16:0] m_alpha;
   logic [8:0]  m_map;
   logic [47:0] m_acc_off, m_gyr_off;
   logic signed [31:0] m_start_roll, m_start_pitch;
   longint m_roll, m_pitch;

   tilt_rsp_type angle_queue[$];
   int  errors = 0;
   int  send_idle = 0, recv_stall = 0;
   longint cycles = 0;

   imu_tilt_complementary_filter u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > STEP_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_div(longint num, longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint root_floor(longint unsigned v);
      longint unsigned res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v -= res + bit_w;
            res = (res >> 1) + bit_w;
         end else begin
            res >>= 1;
         end
         bit_w >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint z, t, nx, ny;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 90 * 65536;
         end else begin
            t = x; x = -y; y = t; z = -90 * 65536;
         end
      end
      for (int i = 0; i < itcf_pkg::CORDIC_ITERATIONS_DEF; i++) begin
         if (y == 0) break;
         if (y > 0) begin
            nx = x + floor_shift(y, i); ny = y - floor_shift(x, i);
            z += longint'(itcf_pkg::atan_lut(5'(i)));
         end else begin
            nx = x - floor_shift(y, i); ny = y + floor_shift(x, i);
            z -= longint'(itcf_pkg::atan_lut(5'(i)));
         end
         x = nx; y = ny;
      end
      return z;
   endfunction

   function automatic longint body_axis(longint v[3], int k);
      logic [1:0] src;
      longint r;
      src = m_map[2*k +: 2];
      r = (src == itcf_pkg::AXIS_X) ? v[0] : (src == itcf_pkg::AXIS_Y) ? v[1]
        : (src == itcf_pkg::AXIS_Z) ? v[2] : 0;
      return m_map[6+k] ? -r : r;
   endfunction

   function automatic tilt_rsp_type predict_angles(tilt_req_type r);
      tilt_rsp_type o;
      longint a[3], g[3];
      longint ax, ay, az, gx, gy, rr, pr, dr, dp, alpha, den, step;
      logic signed [15:0] d;
      o.status = 1'b0;
      if (r.action) begin
         m_roll = m_start_roll;
         m_pitch = m_start_pitch;
      end else if (r.step_us == 0) begin
         o.status = 1'b1;
      end else begin
         step = (r.step_us > 1000000) ? 1000000 : r.step_us;
         for (int k = 0; k < 3; k++) begin
            d = r.acc[k] - $signed(m_acc_off[16*k +: 16]);
            a[k] = d;
            d = r.gyr[k] - $signed(m_gyr_off[16*k +: 16]);
            g[k] = d;
         end
         ax = body_axis(a, 0); ay = body_axis(a, 1); az = body_axis(a, 2);
         gx = body_axis(g, 0); gy = body_axis(g, 1);
         rr = vector_angle(ay * 256, az * 256);
         pr = vector_angle(-ax * 256, root_floor((ay * ay + az * az) << 16));
         den = longint'(itcf_pkg::den_lut(m_grange));
         dr = round_div(gx * step * 65536, den);
         dp = round_div(gy * step * 65536, den);
         alpha = (m_alpha > itcf_pkg::ALPHA_ONE) ? 65536 : m_alpha;
         m_roll = clip32(round_div(alpha * (m_roll + dr) + (65536 - alpha) * rr, 65536));
         m_pitch = clip32(round_div(alpha * (m_pitch + dp) + (65536 - alpha) * pr, 65536));
      end
      o.roll = m_roll[31:0];
      o.pitch = m_pitch[31:0];
      return o;
   endfunction

   function automatic tilt_req_type random_sample();
      tilt_req_type r;
      int sel;
      r.action = ($urandom_range(0, 19) == 0);
      for (int k = 0; k < 3; k++) begin
         sel = $urandom_range(0, 9);
         r.acc[k] = (sel == 0) ? 16'sh8000 : (sel == 1) ? 16'sh7fff : 16'($urandom);
         r.gyr[k] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                 : 16'($signed($urandom_range(0, 2000)) - 1000);
      end
      sel = $urandom_range(0, 19);
      r.step_us = (sel == 0) ? 20'd0 : (sel == 1) ? 20'($urandom_range(1000000, 1048575))
                : (sel == 2) ? 20'($urandom) : 20'($urandom_range(1, 20000));
      return r;
   endfunction

   task automatic write_reg(itcf_pkg::csr_addr_type idx, logic [47:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         itcf_pkg::CSR_GYRO_RANGE:    m_grange = val[1:0];
         itcf_pkg::CSR_BLEND_WEIGHT:  m_alpha = val[16:0];
         itcf_pkg::CSR_AXIS_MAP:      m_map = val[8:0];
         itcf_pkg::CSR_ACCEL_OFFSETS: m_acc_off = val;
         itcf_pkg::CSR_GYRO_OFFSETS:  m_gyr_off = val;
         itcf_pkg::CSR_START_ROLL:    m_start_roll = val[31:0];
         itcf_pkg::CSR_START_PITCH:   m_start_pitch = val[31:0];
         default: ;
      endcase
   endtask

   task automatic send_request(tilt_req_type r, logic known, tilt_rsp_type given);
      tilt_rsp_type p;
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.action;
      req_tdata <= {4'd0, r.step_us, r.gyr[2], r.gyr[1], r.gyr[0],
                    r.acc[2], r.acc[1], r.acc[0]};
      do @(posedge clock); while (!req_tready);
      p = predict_angles(r);
      angle_queue.push_back(known ? given : p);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (angle_queue.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   always @(posedge clock) begin
      tilt_rsp_type e;
      if (!reset) rsp_tready <= ($urandom_range(0, 99) >= recv_stall);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (angle_queue.size() == 0) begin
            $display("%0t: unexpected result roll=%0d pitch=%0d", $time,
                     $signed(rsp_tdata[31:0]), $signed(rsp_tdata[63:32]));
            errors++;
         end else begin
            e = angle_queue.pop_front();
            if (rsp_tdata[31:0] !== e.roll || rsp_tdata[63:32] !== e.pitch
                || rsp_tuser !== e.status) begin
               $display("%0t: expected roll=%0d pitch=%0d status=%0d actual %0d %0d %0d",
                        $time, e.roll, e.pitch, e.status, $signed(rsp_tdata[31:0]),
                        $signed(rsp_tdata[63:32]), rsp_tuser);
               errors++;
            end
         end
      end
   end

   function automatic stim_row_type make_row(logic act, int ax, int ay, int az, int gx,
                                             int gy, int gz, int st, logic known, int ro,
                                             int pi, int s);
      stim_row_type w;
      w.req.action = act;
      w.req.acc[0] = 16'(ax); w.req.acc[1] = 16'(ay); w.req.acc[2] = 16'(az);
      w.req.gyr[0] = 16'(gx); w.req.gyr[1] = 16'(gy); w.req.gyr[2] = 16'(gz);
      w.req.step_us = 20'(st);
      w.known = known;
      w.rsp.roll = 32'(ro); w.rsp.pitch = 32'(pi); w.rsp.status = 1'(s);
      return w;
   endfunction

   initial begin
      stim_row_type rows[$];
      tilt_rsp_type nil;
      int phase_idle[4] = '{0, 72, 0, 37};
      int phase_stall[4] = '{0, 0, 72, 37};
      m_grange = 0; m_alpha = 17'd64225; m_map = 9'd36;
      m_acc_off = '0; m_gyr_off = '0; m_start_roll = 0; m_start_pitch = 0;
      m_roll = 0; m_pitch = 0;
      nil = '{0, 0, 0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero step after reset, then load of zero start angles
      rows.push_back(make_row(0, 1, 2, 3, 4, 5, 6, 0, 1, 0, 0, 1));
      rows.push_back(make_row(1, -1, -1, -1, -1, -1, -1, 'hfffff, 1, 0, 0, 0));
      rows.push_back(make_row(0, 0, 0, 0, 0, 0, 0, 1000, 0, 0, 0, 0));
      rows.push_back(make_row(0, 0, 0, 16384, 0, 0, 0, 10000, 0, 0, 0, 0));
      rows.push_back(make_row(0, 0, 0, -16384, 100, -100, 7, 10000, 0, 0, 0, 0));
      rows.push_back(make_row(0, 0, 16384, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      rows.push_back(make_row(0, 0, -16384, -5, 0, 0, 0, 5000, 0, 0, 0, 0));
      rows.push_back(make_row(0, -32768, -32768, -32768, -32768, -32768, -32768,
                              'hfffff, 0, 0, 0, 0));
      rows.push_back(make_row(0, 32767, 32767, 32767, 32767, 32767, 32767,
                              1000000, 0, 0, 0, 0));
      rows.push_back(make_row(0, 32767, 0, 0, 0, 0, 0, 1000001, 0, 0, 0, 0));
      rows.push_back(make_row(0, -32768, 0, 0, -5, 3, 0, 2, 0, 0, 0, 0));
      foreach (rows[i]) send_request(rows[i].req, rows[i].known, rows[i].rsp);
      drain_results();

      // saturation, unit weight, zero map source, offsets
      write_reg(itcf_pkg::CSR_BLEND_WEIGHT, 48'd131071);
      write_reg(itcf_pkg::CSR_START_ROLL, 48'h7fff0000);
      write_reg(itcf_pkg::CSR_START_PITCH, 48'h80000000);
      write_reg(itcf_pkg::CSR_GYRO_RANGE, 48'd3);
      write_reg(itcf_pkg::CSR_ACCEL_RANGE, 48'd3);
      write_reg(itcf_pkg::CSR_AXIS_MAP, 48'h1ff);
      write_reg(itcf_pkg::CSR_ACCEL_OFFSETS, 48'h8000_7fff_0001);
      write_reg(itcf_pkg::CSR_GYRO_OFFSETS, 48'h0001_8000_7fff);
      send_request(make_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0).req, 1,
                   tilt_rsp_type'{32'h7fff0000, 32'h80000000, 1'b0});
      send_request(make_row(0, 5, 5, 5, 32767, -32768, 0, 1000000, 0, 0, 0, 0).req, 0, nil);
      drain_results();
      write_reg(itcf_pkg::CSR_AXIS_MAP, 48'h0c6);
      send_request(make_row(0, 5, 5, 5, -32768, 32767, 0, 1000000, 0, 0, 0, 0).req, 0, nil);
      send_request(make_row(0, 5, 5, 5, 32767, -32768, 0, 1000000, 0, 0, 0, 0).req, 0, nil);
      drain_results();

      for (int ph = 0; ph < 8; ph++) begin
         send_idle = phase_idle[ph % 4];
         recv_stall = phase_stall[ph % 4];
         write_reg(itcf_pkg::CSR_ACCEL_RANGE, 48'($urandom_range(0, 3)));
         write_reg(itcf_pkg::CSR_GYRO_RANGE, 48'($urandom_range(0, 3)));
         write_reg(itcf_pkg::CSR_BLEND_WEIGHT, (ph == 2) ? 48'd0 : (ph == 5) ? 48'd65536
                                               : 48'($urandom_range(0, 131071)));
         write_reg(itcf_pkg::CSR_AXIS_MAP, (ph == 0) ? 48'd36 : 48'($urandom_range(0, 511)));
         write_reg(itcf_pkg::CSR_ACCEL_OFFSETS, (ph < 2) ? 48'd0 : {16'($urandom), $urandom});
         write_reg(itcf_pkg::CSR_GYRO_OFFSETS, (ph < 2) ? 48'd0 : {16'($urandom), $urandom});
         write_reg(itcf_pkg::CSR_START_ROLL, 48'($urandom));
         write_reg(itcf_pkg::CSR_START_PITCH, 48'($urandom));
         for (int n = 0; n < 180; n++) send_request(random_sample(), 0, nil);
         drain_results();
      end

      if (errors == 0 && angle_queue.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/itcf_pkg.sv
hw/rtl/imu_tilt_complementary_filter.sv
hw/rtl/itcf_checker.sv
tb/tb.sv
